### rtl/sobel_edge_from_color_defines.svh
// Assertion macros shared by the Sobel edge block.
`ifndef SOBEL_EDGE_FROM_COLOR_DEFINES_SVH
`define SOBEL_EDGE_FROM_COLOR_DEFINES_SVH

// Condition and consequence checked at the same clock edge.
`define SBL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence checked at the clock edge after the condition.
`define SBL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sbl_pkg.sv
// Shared types and constants of the Sobel edge block.
`default_nettype none

package sbl_pkg;

  localparam int PIX_W = 8;
  localparam int LW_W  = 12;
  localparam int ROW_W = 12;

  localparam logic [ROW_W-1:0] ROW_MAX  = 12'd4095;
  localparam logic [LW_W-1:0]  LW_RESET = 12'd1920;
  localparam int               MIN_WIDTH = 3;

  // Luma weights for blue, green and red, scaled by 256.
  localparam logic [PIX_W-1:0] W_BLUE  = 8'b00010010;
  localparam logic [PIX_W-1:0] W_GREEN = 8'b10110111;
  localparam logic [PIX_W-1:0] W_RED   = 8'b00110110;

  typedef logic [PIX_W-1:0] pix_t;

  // Window p1..p9 as entries 0..8: top row first, left column first.
  typedef pix_t [8:0] window_t;

  // Per-pixel tags that travel down the pipeline.
  typedef struct packed {
    logic emit;
    logic last;
  } tag_t;

endpackage

`default_nettype wire

### rtl/sbl_ifs.sv
// Channel interfaces of the Sobel edge block: pixels in, results out, width register.
`default_nettype none

interface sbl_pix_if;
  logic                      valid;
  logic                      ready;
  logic [sbl_pkg::PIX_W-1:0] blue;
  logic [sbl_pkg::PIX_W-1:0] green;
  logic [sbl_pkg::PIX_W-1:0] red;
  logic                      start_of_frame;
  modport source (output valid, blue, green, red, start_of_frame, input ready);
  modport sink (input valid, blue, green, red, start_of_frame, output ready);
endinterface

interface sbl_res_if;
  logic                      valid;
  logic                      ready;
  logic [sbl_pkg::PIX_W-1:0] edge_res;
  logic                      row_end;
  modport source (output valid, edge_res, row_end, input ready);
  modport sink (input valid, edge_res, row_end, output ready);
endinterface

interface sbl_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [sbl_pkg::LW_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/sbl_mag.sv
// Sobel gradient magnitude of one 3x3 window of gray values.
`default_nettype none

module sbl_mag (
  input  sbl_pkg::window_t win,
  output sbl_pkg::pix_t    mag
);

  logic signed [11:0] p [9];
  logic signed [11:0] gx;
  logic signed [11:0] gy;
  logic        [10:0] ax;
  logic        [10:0] ay;
  logic        [11:0] sum;

  // Widen each gray value to a positive signed number.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      p[k] = $signed({4'b0000, win[k]});
    end
  end

  // Horizontal and vertical gradients, each within plus or minus 1020.
  assign gx = (p[2] - p[0]) + ((p[5] - p[3]) <<< 1) + (p[8] - p[6]);
  assign gy = (p[0] - p[6]) + ((p[1] - p[7]) <<< 1) + (p[2] - p[8]);

  // Absolute values, sum and scale down by eight.
  always_comb begin
    logic signed [11:0] nx;
    logic signed [11:0] ny;
    nx  = -gx;
    ny  = -gy;
    ax  = gx[11] ? nx[10:0] : gx[10:0];
    ay  = gy[11] ? ny[10:0] : gy[10:0];
    sum = {1'b0, ax} + {1'b0, ay};
    mag = sum[10:3];
  end

endmodule

`default_nettype wire

### rtl/sobel_edge_from_color.sv
// Top level of the Sobel edge block: gray conversion, line buffers, window, output register.
// A result is valid once its pixel has passed the first stage, the window stage and the output register.
// Throughput: one pixel per cycle; the pipeline advances whenever the output register is free.
// A stall on the result side holds every stage, line buffer reads included.
// Reset clears counters, window, pipeline valid bits and sets line_width to 1920.
// Line buffer contents are not cleared; each entry is written before it is used.
`default_nettype none

module sobel_edge_from_color #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire           clk,
  input  wire           rst,
  sbl_pix_if.sink       pix,
  sbl_res_if.source     res,
  sbl_cfg_if.sink       cfg
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > sbl_pkg::LW_W) ? WW : sbl_pkg::LW_W;
  localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MIN_W_E = EW'(sbl_pkg::MIN_WIDTH);

  // Width register.
  logic [sbl_pkg::LW_W-1:0] line_width;

  // Position counters.
  logic [CW-1:0]              column_count;
  logic [CW-1:0]              column_count_next;
  logic [sbl_pkg::ROW_W-1:0]  row_count;
  logic [sbl_pkg::ROW_W-1:0]  row_count_next;

  // Line buffers and their read registers.
  sbl_pkg::pix_t older_line [MAX_WIDTH];
  sbl_pkg::pix_t newer_line [MAX_WIDTH];
  sbl_pkg::pix_t older_rd;
  sbl_pkg::pix_t newer_rd;

  // Pipeline registers.
  logic              s1_valid;
  logic              s1_fwd;
  logic [CW-1:0]     s1_col;
  sbl_pkg::pix_t     s1_gray;
  sbl_pkg::tag_t     s1_tag;
  logic              s2_valid;
  sbl_pkg::tag_t     s2_tag;
  sbl_pkg::window_t  win;
  logic              res_valid;
  sbl_pkg::pix_t     res_edge;
  logic              res_row_end;

  // Combinational signals.
  logic              en;
  logic              acc;
  logic [EW-1:0]     eff_w;
  logic [EW-1:0]     lw_ext;
  logic [CW-1:0]     pix_col;
  logic [sbl_pkg::ROW_W-1:0] pix_row;
  logic              pix_last;
  logic              pix_emit;
  logic [15:0]       gray_sum;
  sbl_pkg::pix_t     top_val;
  sbl_pkg::pix_t     mid_val;
  sbl_pkg::pix_t     mag;

  // Handshake: the whole pipeline moves when the output register can take a result.
  assign en        = !res_valid || res.ready;
  assign pix.ready = en && !rst;
  assign acc       = pix.valid && pix.ready;
  assign cfg.ready = 1'b1;

  // Width register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= sbl_pkg::LW_RESET;
    end else if (cfg.valid && cfg.ready) begin
      line_width <= cfg.data;
    end
  end

  // Effective width, clamped to the supported range.
  always_comb begin
    lw_ext = EW'(line_width);
    if (lw_ext < MIN_W_E) begin
      eff_w = MIN_W_E;
    end else if (lw_ext > MAX_W_E) begin
      eff_w = MAX_W_E;
    end else begin
      eff_w = lw_ext;
    end
  end

  // Column and row of the incoming pixel, and the counters after it.
  always_comb begin
    logic [CW-1:0]             cnt_base;
    logic [sbl_pkg::ROW_W-1:0] row_base;
    logic [sbl_pkg::ROW_W-1:0] row_inc;
    logic [EW-1:0]             col_inc;
    cnt_base = pix.start_of_frame ? '0 : column_count;
    row_base = pix.start_of_frame ? '0 : row_count;
    row_inc  = (row_base == sbl_pkg::ROW_MAX) ? row_base : row_base + 1'b1;
    if (EW'(cnt_base) >= eff_w) begin
      pix_col = '0;
      pix_row = row_inc;
    end else begin
      pix_col = cnt_base;
      pix_row = row_base;
    end
    col_inc  = EW'(pix_col) + 1'b1;
    pix_last = (col_inc == eff_w);
    pix_emit = (pix_row >= sbl_pkg::ROW_W'(2)) && (pix_col >= CW'(2));
    if (col_inc >= eff_w) begin
      column_count_next = '0;
      row_count_next    = (pix_row == sbl_pkg::ROW_MAX) ? pix_row : pix_row + 1'b1;
    end else begin
      column_count_next = col_inc[CW-1:0];
      row_count_next    = pix_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (acc) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Gray value of the incoming pixel.
  assign gray_sum = {8'b0, sbl_pkg::W_BLUE}  * {8'b0, pix.blue}
                  + {8'b0, sbl_pkg::W_GREEN} * {8'b0, pix.green}
                  + {8'b0, sbl_pkg::W_RED}   * {8'b0, pix.red};

  // First stage: register the pixel and note a hit on the column being written.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col  <= pix_col;
      s1_gray <= gray_sum[15:8];
      s1_tag  <= '{emit: pix_emit, last: pix_last};
      s1_fwd  <= s1_valid && (s1_col == pix_col);
    end
  end

  // Line buffers: read at the incoming column, write back the column in the first stage.
  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      older_line[s1_col] <= mid_val;
      newer_line[s1_col] <= s1_gray;
    end
    if (acc) begin
      older_rd <= older_line[pix_col];
      newer_rd <= newer_line[pix_col];
    end
  end

  // When the previous pixel wrote the same column, its values sit in the window's right column.
  assign top_val = s1_fwd ? win[5] : older_rd;
  assign mid_val = s1_fwd ? win[8] : newer_rd;

  // Second stage: shift the window by one column.
  always_ff @(posedge clk) begin
    if (rst) begin
      win      <= '0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= top_val;
        win[3] <= win[4];
        win[4] <= win[5];
        win[5] <= mid_val;
        win[6] <= win[7];
        win[7] <= win[8];
        win[8] <= s1_gray;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      s2_tag <= s1_tag;
    end
  end

  // Gradient magnitude of the current window.
  sbl_mag u_mag (
    .win (win),
    .mag (mag)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= s2_valid && s2_tag.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_edge    <= mag;
      res_row_end <= s2_tag.last;
    end
  end

  assign res.valid    = res_valid;
  assign res.edge_res = res_edge;
  assign res.row_end  = res_row_end;

  // Checks on counters and pipeline.
  `include "sobel_edge_from_color_defines.svh"

  `SBL_ASSERT_NEXT(a_sof_restart, clk, rst, acc && pix.start_of_frame, (row_count == '0) && (column_count == CW'(1)), "start of frame did not restart the counters")
  `SBL_ASSERT_NEXT(a_row_wrap, clk, rst, acc && pix_last, column_count == '0, "column counter did not wrap after the last pixel of a row")
  `SBL_ASSERT_NEXT(a_result_out, clk, rst, en && s2_valid && s2_tag.emit, res.valid, "interior pixel produced no result")
  `SBL_ASSERT_SAME(a_emit_col, clk, rst, s1_valid && s1_tag.emit, s1_col >= CW'(2), "result tagged for a border column")

endmodule

`default_nettype wire
